FILE: design/mpi_pkg.sv
// Package for the modular power and inverse block.
// Holds the sequencer state type and the fixed operand widths; no dependencies.
package mpi_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned EXP_IN_W = 32;
    localparam int unsigned CNT_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SCAN,
        S_MUL_ACC,
        S_SQUARE,
        S_FINISH
    } t_state;

    localparam logic OP_POWER = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

endpackage

FILE: design/mpi_modmul.sv
// Iterative modular multiplier, one bit of the multiplier operand per cycle.
// Depends on mpi_pkg for the operand width.
module mpi_modmul
    import mpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    input  logic [VAL_W-1:0] i_m,
    output logic             o_done,
    output logic [VAL_W-1:0] o_prod
);

    // The a operand must not exceed the modulus; b may be any value.
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] r_a;
    logic [VAL_W-1:0] r_b;
    logic [VAL_W-1:0] r_m;

    logic [VAL_W:0] w_dbl;
    logic [VAL_W:0] w_dbl_red;
    logic [VAL_W:0] w_sum;
    logic [VAL_W:0] w_sum_red;

    always_comb begin
        w_dbl = {r_acc, 1'b0};
        if (w_dbl >= {1'b0, r_m}) begin
            w_dbl_red = w_dbl - {1'b0, r_m};
        end else begin
            w_dbl_red = w_dbl;
        end
        w_sum = w_dbl_red + (r_b[VAL_W-1] ? {1'b0, r_a} : '0);
        if (w_sum >= {1'b0, r_m}) begin
            w_sum_red = w_sum - {1'b0, r_m};
        end else begin
            w_sum_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VAL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= w_sum_red[VAL_W-1:0];
            r_b   <= {r_b[VAL_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: design/modular_power_and_inverse_top.sv
// Top level of the modular power and inverse block: sequencer, exponent
// register and output register around the shared multiplier mpi_modmul.
// Depends on mpi_pkg.

// The block computes base to the power exponent modulo modulus (operation 0),
// or the Fermat inverse of base, using exponent modulus minus two (operation 1),
// which is correct only for a prime modulus and is not checked. An effective
// exponent of zero returns 1 for any modulus, and an inverse with a modulus
// below three returns 1. One transfer in gives exactly one transfer out. The
// block works on one item at a time and stalls its input until the result has
// been placed in the output register; a waiting result does not block the next
// input transfer. Every modular multiplication goes through one shared
// shift-add unit. An item passes through the input transfer, a reduction of
// the base, a scan of each exponent bit up to the highest set bit of the
// effective exponent, a squaring for every bit below that highest set bit, a
// multiplication for every set bit, and the load of the output register. A
// zero exponent or a zero modulus skips the multiplications. Only the low
// EXPONENT_BITS bits of the effective exponent are used.
module modular_power_and_inverse_top
    import mpi_pkg::*;
#(
    parameter int unsigned EXPONENT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [VAL_W-1:0]    i_base,
    input  logic [EXP_IN_W-1:0] i_exponent,
    input  logic [VAL_W-1:0]    i_modulus,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VAL_W-1:0]    o_result
);

    t_state r_state;
    t_state n_state;

    // Exponent is consumed from its least significant bit; r_sq holds the
    // running square and r_acc the running product.
    logic [EXPONENT_BITS-1:0] r_exp;
    logic [EXPONENT_BITS-1:0] n_exp;
    logic [VAL_W-1:0]         r_acc;
    logic [VAL_W-1:0]         n_acc;
    logic [VAL_W-1:0]         r_sq;
    logic [VAL_W-1:0]         n_sq;
    logic [VAL_W-1:0]         r_m;
    logic [VAL_W-1:0]         n_m;
    logic [VAL_W-1:0]         r_res;
    logic [VAL_W-1:0]         n_res;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic                     r_issued;
    logic                     n_issued;

    logic                 w_in_take;
    logic                 w_out_free;
    logic [EXP_IN_W-1:0]  w_exp_in;
    logic [63:0]          w_exp_wide;
    logic [EXPONENT_BITS-1:0] w_exp_eff;

    logic             w_mul_start;
    logic [VAL_W-1:0] w_mul_a;
    logic [VAL_W-1:0] w_mul_b;
    logic             w_mul_done;
    logic [VAL_W-1:0] w_mul_prod;

    assign w_in_take  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Effective exponent: the given one, or modulus minus two for the inverse.
    always_comb begin
        if (i_operation == OP_INVERSE) begin
            if (i_modulus < VAL_W'(3)) begin
                w_exp_in = '0;
            end else begin
                w_exp_in = {1'b0, i_modulus - VAL_W'(2)};
            end
        end else begin
            w_exp_in = i_exponent;
        end
        w_exp_wide = {32'd0, w_exp_in};
        w_exp_eff  = w_exp_wide[EXPONENT_BITS-1:0];
    end

    mpi_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_m     (r_m),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // Next state and next values of the data registers.
    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_m         = r_m;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_issued    = r_issued;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_exp = w_exp_eff;
                    n_sq  = i_base;
                    n_m   = i_modulus;
                    if (w_exp_eff == '0) begin
                        n_acc   = VAL_W'(1);
                        n_state = S_FINISH;
                    end else if (i_modulus == '0) begin
                        // Out of range modulus: no reduction is possible.
                        n_acc   = '0;
                        n_state = S_FINISH;
                    end else begin
                        n_acc   = VAL_W'(1);
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_sq     = w_mul_prod;
                    n_issued = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_exp[0]) begin
                    n_state = S_MUL_ACC;
                end else begin
                    n_state = S_SQUARE;
                end
            end
            S_MUL_ACC: begin
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_acc    = w_mul_prod;
                    n_issued = 1'b0;
                    if (r_exp[EXPONENT_BITS-1:1] == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_SQUARE: begin
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_sq     = w_mul_prod;
                    n_exp    = {1'b0, r_exp[EXPONENT_BITS-1:1]};
                    n_issued = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_res       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Multiplier launch and operand selection. The unit latches its operands
    // at launch, and r_issued keeps a launch to a single cycle per state.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = r_acc;
        w_mul_b     = r_sq;
        case (r_state)
            S_REDUCE: begin
                w_mul_start = !r_issued;
                w_mul_a     = VAL_W'(1);
                w_mul_b     = r_sq;
            end
            S_MUL_ACC: begin
                w_mul_start = !r_issued;
                w_mul_a     = r_acc;
                w_mul_b     = r_sq;
            end
            S_SQUARE: begin
                w_mul_start = !r_issued;
                w_mul_a     = r_sq;
                w_mul_b     = r_sq;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_issued    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_issued    <= n_issued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_m   <= n_m;
        r_res <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

endmodule

FILE: design/mpi_checker.sv
// Port-level checker for modular_power_and_inverse_top, with its bind.
// Depends on mpi_pkg for the operand width.
module mpi_checker
    import mpi_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [VAL_W-1:0] o_result
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("result changed or vanished while stalled");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A result is below the modulus, is one, or is zero for a zero modulus, so never all ones.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result != {VAL_W{1'b1}})
        else $error("result out of range");

    // Reset leaves the block empty and ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind modular_power_and_inverse_top mpi_checker u_mpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for modular_power_and_inverse_top, with a driver and a monitor on the
// valid/stall channels. Depends on mpi_pkg and the block itself.
module tb;
    import mpi_pkg::*;

    // Exponent width the block is built with; the expected results are masked the same way.
    localparam int unsigned EXP_BITS = 32;
    // A safe settling time after the last result.
    localparam int unsigned TAIL_CYCLES = 2500;
    // The receiver's long hold-off starts once this many results have been transferred.
    localparam int unsigned HOLD_AFTER = 40;
    localparam int unsigned HOLD_CYCLES = 6000;

    typedef struct {
        logic               op;
        logic [VAL_W-1:0]   base;
        logic [EXP_IN_W-1:0] expo;
        logic [VAL_W-1:0]   modulus;
        bit                 drain_first;
    } t_mpi_request;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                o_in_stall;
    logic                in_op;
    logic [VAL_W-1:0]    in_base;
    logic [EXP_IN_W-1:0] in_expo;
    logic [VAL_W-1:0]    in_modulus;
    logic                o_out_valid;
    logic                out_stall;
    logic [VAL_W-1:0]    o_result;

    t_mpi_request        pending_items[$];
    logic [VAL_W-1:0]    expected_results[$];
    t_mpi_request        offered;
    int unsigned         mismatch_count;
    int unsigned         results_checked;

    modular_power_and_inverse_top #(
        .EXPONENT_BITS(EXP_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (in_op),
        .i_base      (in_base),
        .i_exponent  (in_expo),
        .i_modulus   (in_modulus),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_result    (o_result)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Right-to-left square-and-multiply. The inverse operation swaps in modulus minus two as
    // the exponent, or zero when the modulus is below three. A zero effective exponent always
    // gives 1; a zero modulus with a nonzero exponent gives 0, as no reduction is possible.
    function automatic logic [VAL_W-1:0] predict_residue(input t_mpi_request req);
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        e = {32'd0, req.expo};
        m = {33'd0, req.modulus};
        if (req.op == OP_INVERSE) begin
            e = (m < 64'd3) ? 64'd0 : m - 64'd2;
        end
        e = e & ((64'd1 << EXP_BITS) - 64'd1);
        if (e == 64'd0) begin
            return VAL_W'(1);
        end
        if (m == 64'd0) begin
            return '0;
        end
        acc = 64'd1;
        sq = {33'd0, req.base};
        while (e != 64'd0) begin
            if (e[0]) begin
                acc = (acc * sq) % m;
            end
            e = e >> 1;
            if (e != 64'd0) begin
                sq = (sq * sq) % m;
            end
        end
        return acc[VAL_W-1:0];
    endfunction

    task automatic queue_item(input logic op, input logic [VAL_W-1:0] base,
                              input logic [EXP_IN_W-1:0] expo,
                              input logic [VAL_W-1:0] modulus, input bit drain_first);
        t_mpi_request req;
        req.op = op;
        req.base = base;
        req.expo = expo;
        req.modulus = modulus;
        req.drain_first = drain_first;
        pending_items = {pending_items, req};
    endtask

    // A handful of primes, from the smallest legal one up to the largest 31-bit prime, so that
    // the inverse results are true inverses.
    function automatic logic [VAL_W-1:0] pick_prime(input int unsigned idx);
        case (idx)
            0: return 31'd3;
            1: return 31'd5;
            2: return 31'd13;
            3: return 31'd31;
            4: return 31'd97;
            5: return 31'd7919;
            6: return 31'd65537;
            7: return 31'd998244353;
            8: return 31'd1000000007;
            default: return 31'd2147483647;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] wanted,
                                   input logic [VAL_W-1:0] seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH (%s) at result %0d: expected %0d, got %0d", what,
                     results_checked, wanted, seen);
        end
    endtask

    // Driver. The sender works in bursts: after a burst of transfers it may drop valid for a
    // random gap, which now and then is long enough to leave the block idle between items.
    // An item marked drain_first is held back until every expected result has been seen.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_op <= OP_POWER;
            in_base <= '0;
            in_expo <= '0;
            in_modulus <= 31'd1;
            burst_left = 1;
            gap_left = 0;
        end else begin
            // A transfer at this edge: record what the block owes us for it.
            if (in_valid && !o_in_stall) begin
                expected_results = {expected_results, predict_residue(offered)};
            end
            // The payload may only move once the current one is gone or none is offered.
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             (!pending_items[0].drain_first ||
                              expected_results.size() == 0)) begin
                    offered = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_op <= offered.op;
                    in_base <= offered.base;
                    in_expo <= offered.expo;
                    in_modulus <= offered.modulus;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        case ($urandom_range(0, 6))
                            0, 1: gap_left = 0;
                            2:    gap_left = $urandom_range(300, 2500);
                            default: gap_left = $urandom_range(1, 30);
                        endcase
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. The stall pattern steps, by bits 13:12 of its cycle counter, through no stall,
    // light and heavy random stall, and a regular on/off pattern. Once, after HOLD_AFTER results,
    // the receiver holds off for a HOLD_CYCLES countdown so that a result waits in the output
    // register and the next item completes behind it, which forces the block to stall its input.
    int unsigned rx_cycle;
    int unsigned rx_transfers;
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_cycle = 0;
            rx_transfers = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            rx_cycle++;
            if (o_out_valid === 1'b1 && !out_stall) begin
                rx_transfers++;
            end
            if (!hold_done && rx_transfers >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (rx_cycle[13:12])
                    2'd0: out_stall <= 1'b0;
                    2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                    2'd2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= rx_cycle[2];
                endcase
            end
        end
    end

    // Monitor. Every result transfer is matched against the oldest expectation; a result with
    // nothing expected is a failure of its own.
    logic [VAL_W-1:0] wanted;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_result);
            end else begin
                wanted = expected_results.pop_front();
                if (o_result !== wanted) begin
                    report_mismatch("result", wanted, o_result);
                end
            end
            results_checked++;
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned   n;
        int unsigned   kind;
        int unsigned   w;
        int unsigned   ew;
        logic          op;
        logic [VAL_W-1:0]    base;
        logic [EXP_IN_W-1:0] expo;
        logic [VAL_W-1:0]    modulus;

        mismatch_count = 0;
        results_checked = 0;
        i_rst_n = 1'b0;

        // Directed items: zero exponents (also with modulus one), field extremes, a base not
        // below its modulus, the out-of-range zero modulus, inverses with a modulus below
        // three, true inverses over primes and one over a composite modulus.
        queue_item(OP_POWER, 31'd0, 32'd0, 31'd1, 1'b0);
        queue_item(OP_POWER, 31'd5, 32'd0, 31'd7, 1'b0);
        queue_item(OP_POWER, 31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 1'b0);
        queue_item(OP_POWER, 31'd0, 32'd5, 31'd13, 1'b0);
        queue_item(OP_POWER, 31'd2, 32'd10, 31'd1000, 1'b0);
        queue_item(OP_POWER, 31'd3, 32'd1, 31'd1, 1'b0);
        queue_item(OP_POWER, 31'h7FFFFFFF, 32'd1, 31'd10, 1'b0);
        queue_item(OP_POWER, 31'd12345, 32'hFFFFFFFF, 31'd2147483647, 1'b0);
        queue_item(OP_POWER, 31'd3, 32'h80000000, 31'd2147483647, 1'b0);
        queue_item(OP_POWER, 31'h2AAAAAAA, 32'h55555555, 31'h55555555, 1'b0);
        queue_item(OP_POWER, 31'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAB, 1'b0);
        queue_item(OP_POWER, 31'd9, 32'd0, 31'd0, 1'b0);
        queue_item(OP_POWER, 31'd9, 32'd7, 31'd0, 1'b0);
        queue_item(OP_INVERSE, 31'd17, 32'hFFFFFFFF, 31'd0, 1'b0);
        queue_item(OP_INVERSE, 31'd17, 32'd3, 31'd1, 1'b0);
        queue_item(OP_INVERSE, 31'h7FFFFFFF, 32'd0, 31'd2, 1'b0);
        queue_item(OP_INVERSE, 31'd2, 32'd0, 31'd3, 1'b0);
        queue_item(OP_INVERSE, 31'd2, 32'd0, 31'd2147483647, 1'b0);
        queue_item(OP_INVERSE, 31'd123456789, 32'd99, 31'd1000000007, 1'b0);
        queue_item(OP_INVERSE, 31'd3, 32'd0, 31'd998244353, 1'b0);
        queue_item(OP_INVERSE, 31'd65536, 32'd0, 31'd65537, 1'b0);
        queue_item(OP_INVERSE, 31'd0, 32'd0, 31'd7, 1'b0);
        queue_item(OP_INVERSE, 31'd2147483646, 32'd0, 31'd13, 1'b0);
        queue_item(OP_INVERSE, 31'd4, 32'd0, 31'd15, 1'b0);

        // Random items. Exponent and modulus widths are drawn at random so that most items
        // are short and a fair share still use the full width. The sender drains the block
        // before the first random item and again later in the run.
        for (n = 0; n < 518; n++) begin
            kind = $urandom_range(0, 99);
            w = $urandom_range(1, 31);
            modulus = 31'($urandom) & (31'h7FFFFFFF >> (31 - w));
            if (modulus == '0) begin
                modulus = 31'd1;
            end
            case ($urandom_range(0, 3))
                0:       base = 31'($urandom_range(0, 20));
                1:       base = modulus + 31'($urandom_range(0, 5));
                default: base = 31'($urandom);
            endcase
            ew = $urandom_range(1, 32);
            expo = 32'($urandom) & (32'hFFFFFFFF >> (32 - ew));
            op = OP_POWER;
            if (kind >= 45 && kind < 55) begin
                expo = 32'($urandom);
            end else if (kind >= 55 && kind < 80) begin
                op = OP_INVERSE;
                modulus = pick_prime($urandom_range(0, 9));
                expo = 32'($urandom);
                if (base % modulus == '0) begin
                    base = base + 31'd1;
                end
            end else if (kind >= 80) begin
                op = OP_INVERSE;
            end
            queue_item(op, base, expo, modulus, (n == 0 || n == 300));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Anything the block sends after this point is caught by the monitor as unexpected.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
